@@ rtl/sled_pkg.sv @@
// Shared types and constants for the string literal escape decoder.
// Used by every module in rtl; depends on nothing else.
package sled_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;

  localparam logic [LenW-1:0] MaxLengthReset = 16'd1024;

  // Decoder mode.
  typedef enum logic [2:0] {
    M_NORMAL   = 3'd0,
    M_ESC      = 3'd1,
    M_OCT2     = 3'd2,
    M_OCT3     = 3'd3,
    M_DISC     = 3'd4,
    M_DISC_ESC = 3'd5
  } mode_t;

  // What one input byte does to the output side.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_EMIT = 2'd1,
    ACT_DONE = 2'd2,
    ACT_FAIL = 2'd3
  } act_t;

  // Result kinds.
  localparam logic [1:0] K_DATA  = 2'd0;
  localparam logic [1:0] K_DONE  = 2'd1;
  localparam logic [1:0] K_ERROR = 2'd2;

  // Error codes.
  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_EOF   = 2'd1;
  localparam logic [1:0] E_OCTAL = 2'd2;
  localparam logic [1:0] E_LONG  = 2'd3;

  // Characters of interest.
  localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_A = 8'h61;
  localparam logic [ByteW-1:0] CH_B = 8'h62;
  localparam logic [ByteW-1:0] CH_T = 8'h74;
  localparam logic [ByteW-1:0] CH_N = 8'h6E;
  localparam logic [ByteW-1:0] CH_F = 8'h66;
  localparam logic [ByteW-1:0] CH_R = 8'h72;

  // Upper five bits shared by the digits '0' to '7'.
  localparam logic [4:0] OctalPrefix = 5'b00110;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_input;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [1:0]       kind;
    logic [1:0]       error_code;
    logic [LenW-1:0]  str_length;
    logic             last;
  } res_t;

  // Handshake between the decode core and the stages around it.
  typedef struct packed {
    logic advance;
    logic load;
  } core_ctl_t;

endpackage

@@ rtl/sled_in_stage.sv @@
// Input register of the escape decoder: holds one accepted byte for the core.
// Depends on sled_pkg.
module sled_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  sled_pkg::item_t    item_in,
  input  logic               advance,
  output logic               held_valid,
  output sled_pkg::item_t    held_item
);

  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item_in;
    end
  end

endmodule

@@ rtl/sled_core.sv @@
// Decode core: mode, octal acc, length count; one byte per cycle unless stalled.
// Depends on sled_pkg.
module sled_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [sled_pkg::LenW-1:0] cfg_write_data,
  input  logic                      held_valid,
  input  sled_pkg::item_t           held_item,
  input  logic                      out_free,
  output sled_pkg::core_ctl_t       ctl,
  output sled_pkg::res_t            res
);

  logic [sled_pkg::LenW-1:0]  max_length;
  sled_pkg::mode_t            mode;
  sled_pkg::mode_t            mode_next;
  logic [sled_pkg::ByteW-1:0] octal_acc;
  logic [sled_pkg::ByteW-1:0] octal_acc_next;
  logic [sled_pkg::LenW-1:0]  count;
  logic [sled_pkg::LenW-1:0]  count_next;

  logic [sled_pkg::ByteW-1:0] b;
  logic                       eoi;
  logic                       is_oct;
  logic [2:0]                 digit;
  logic                       esc_known;
  logic [sled_pkg::ByteW-1:0] esc_val;
  sled_pkg::act_t             act;
  logic [sled_pkg::ByteW-1:0] emit_val;
  logic [1:0]                 fail_code;
  sled_pkg::mode_t            fail_mode;
  logic                       discarding;

  assign b          = held_item.in_byte;
  assign eoi        = held_item.end_of_input;
  assign is_oct     = (b[7:3] == sled_pkg::OctalPrefix);
  assign digit      = b[2:0];
  assign discarding = (mode == sled_pkg::M_DISC) || (mode == sled_pkg::M_DISC_ESC);

  always_comb begin
    esc_known = 1'b1;
    unique case (b)
      sled_pkg::CH_A: esc_val = 8'd7;
      sled_pkg::CH_B: esc_val = 8'd8;
      sled_pkg::CH_T: esc_val = 8'd9;
      sled_pkg::CH_N: esc_val = 8'd10;
      sled_pkg::CH_F: esc_val = 8'd12;
      sled_pkg::CH_R: esc_val = 8'd13;
      default: begin
        esc_known = 1'b0;
        esc_val   = b;
      end
    endcase
  end

  // Classify the held byte; an emit that would pass the limit turns into an error.
  always_comb begin
    act       = sled_pkg::ACT_NONE;
    emit_val  = b;
    fail_code = sled_pkg::E_NONE;
    fail_mode = sled_pkg::M_NORMAL;
    if (discarding) begin
      act = sled_pkg::ACT_NONE;
    end else if (eoi) begin
      act       = sled_pkg::ACT_FAIL;
      fail_code = sled_pkg::E_EOF;
    end else begin
      unique case (mode)
        sled_pkg::M_ESC: begin
          if (esc_known) begin
            act      = sled_pkg::ACT_EMIT;
            emit_val = esc_val;
          end else if (!is_oct) begin
            act = sled_pkg::ACT_EMIT;
          end
        end
        sled_pkg::M_OCT2, sled_pkg::M_OCT3: begin
          if (!is_oct) begin
            act       = sled_pkg::ACT_FAIL;
            fail_code = sled_pkg::E_OCTAL;
            if (b == sled_pkg::CH_QUOTE) begin
              fail_mode = sled_pkg::M_NORMAL;
            end else if (b == sled_pkg::CH_BSLASH) begin
              fail_mode = sled_pkg::M_DISC_ESC;
            end else begin
              fail_mode = sled_pkg::M_DISC;
            end
          end else if (mode == sled_pkg::M_OCT3) begin
            act      = sled_pkg::ACT_EMIT;
            emit_val = octal_acc + {5'd0, digit};
          end
        end
        default: begin
          if (b == sled_pkg::CH_QUOTE) begin
            act = sled_pkg::ACT_DONE;
          end else if (b != sled_pkg::CH_BSLASH) begin
            act = sled_pkg::ACT_EMIT;
          end
        end
      endcase
    end
    if (act == sled_pkg::ACT_EMIT && count >= max_length) begin
      act       = sled_pkg::ACT_FAIL;
      fail_code = sled_pkg::E_LONG;
      fail_mode = sled_pkg::M_DISC;
    end
  end

  assign ctl.load    = held_valid && (act != sled_pkg::ACT_NONE) && out_free;
  assign ctl.advance = held_valid && ((act == sled_pkg::ACT_NONE) || out_free);

  // Next state.
  always_comb begin
    mode_next      = mode;
    octal_acc_next = octal_acc;
    count_next     = count;
    unique case (act)
      sled_pkg::ACT_EMIT: begin
        mode_next      = sled_pkg::M_NORMAL;
        octal_acc_next = '0;
        count_next     = count + 16'd1;
      end
      sled_pkg::ACT_DONE: begin
        mode_next      = sled_pkg::M_NORMAL;
        octal_acc_next = '0;
        count_next     = '0;
      end
      sled_pkg::ACT_FAIL: begin
        mode_next      = fail_mode;
        octal_acc_next = '0;
        count_next     = '0;
      end
      default: begin
        if (discarding) begin
          octal_acc_next = '0;
          count_next     = '0;
          if (eoi) begin
            mode_next = sled_pkg::M_NORMAL;
          end else if (mode == sled_pkg::M_DISC_ESC) begin
            mode_next = sled_pkg::M_DISC;
          end else if (b == sled_pkg::CH_QUOTE) begin
            mode_next = sled_pkg::M_NORMAL;
          end else if (b == sled_pkg::CH_BSLASH) begin
            mode_next = sled_pkg::M_DISC_ESC;
          end
        end else if (mode == sled_pkg::M_ESC) begin
          mode_next      = sled_pkg::M_OCT2;
          octal_acc_next = {digit[1:0], 6'd0};
        end else if (mode == sled_pkg::M_OCT2) begin
          mode_next      = sled_pkg::M_OCT3;
          octal_acc_next = octal_acc + {2'd0, digit, 3'd0};
        end else begin
          mode_next = sled_pkg::M_ESC;
        end
      end
    endcase
  end

  // Result fields.
  always_comb begin
    res = '0;
    unique case (act)
      sled_pkg::ACT_EMIT: begin
        res.out_byte   = emit_val;
        res.kind       = sled_pkg::K_DATA;
        res.str_length = count + 16'd1;
      end
      sled_pkg::ACT_DONE: begin
        res.kind       = sled_pkg::K_DONE;
        res.str_length = count;
        res.last       = 1'b1;
      end
      sled_pkg::ACT_FAIL: begin
        res.kind       = sled_pkg::K_ERROR;
        res.error_code = fail_code;
        res.str_length = count;
        res.last       = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= sled_pkg::MaxLengthReset;
    end else if (cfg_write_en) begin
      max_length <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= sled_pkg::M_NORMAL;
      octal_acc <= '0;
      count     <= '0;
    end else if (ctl.advance) begin
      mode      <= mode_next;
      octal_acc <= octal_acc_next;
      count     <= count_next;
    end
  end

  // An error or completion closes the string, so the count starts again.
  a_end_clears_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && res.last) |=> (count == '0))
    else $error("count not cleared after end of string");

  // A data result reports the count that the core then holds.
  a_data_len_tracks: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && res.kind == sled_pkg::K_DATA) |=> (count == $past(res.str_length)))
    else $error("count does not match reported length");

  // Discarding never produces a result.
  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    (held_valid && discarding) |-> !ctl.load)
    else $error("result produced while discarding");

  // The byte after a backslash in discard mode is skipped unless input ends.
  a_disc_esc_skip: assert property (@(posedge clk) disable iff (rst)
    (ctl.advance && mode == sled_pkg::M_DISC_ESC && !eoi) |=> (mode == sled_pkg::M_DISC))
    else $error("escaped byte not skipped while discarding");

endmodule

@@ rtl/sled_out_stage.sv @@
// Result register of the escape decoder: holds one result until it is taken.
// Depends on sled_pkg.
module sled_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  sled_pkg::res_t res_in,
  output logic           out_free,
  output logic           result_valid,
  input  logic           result_ready,
  output sled_pkg::res_t res_out
);

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

@@ rtl/string_literal_escape_decoder.sv @@
// Decodes the bodies of quoted string literals one raw byte per transaction, handling
// C-style escapes (\a \b \t \n \f \r, three-digit octal, and any other escaped byte
// standing for itself), and gives at most one result per byte: a data byte, a
// completion at the closing quote, or an error; after an octal or length error, bytes
// are dropped up to the next unescaped quote or end of input. One byte is accepted
// every cycle when the result side keeps up. A byte is held in the input register
// while the core decodes it combinationally and updates its state, and its result is
// then registered in the result register; if that register is not free, the byte
// waits in the input register. There is no start-up sweep: the block takes bytes
// from the first cycle after reset. Bytes that give no result (an opening backslash,
// octal digits, discarded bytes) still pass through the input register and the core.
// Depends on sled_pkg, sled_in_stage, sled_core and sled_out_stage.
module string_literal_escape_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [1:0]  error_code,
  output logic [15:0] str_length,
  output logic        last
);

  sled_pkg::item_t     item_in;
  sled_pkg::item_t     held_item;
  logic                held_valid;
  logic                out_free;
  sled_pkg::core_ctl_t ctl;
  sled_pkg::res_t      core_res;
  sled_pkg::res_t      res_out;

  assign item_in.in_byte      = in_byte;
  assign item_in.end_of_input = end_of_input;

  sled_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_in    (item_in),
    .advance    (ctl.advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sled_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .held_valid     (held_valid),
    .held_item      (held_item),
    .out_free       (out_free),
    .ctl            (ctl),
    .res            (core_res)
  );

  sled_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (ctl.load),
    .res_in       (core_res),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .res_out      (res_out)
  );

  assign out_byte   = res_out.out_byte;
  assign kind       = res_out.kind;
  assign error_code = res_out.error_code;
  assign str_length = res_out.str_length;
  assign last       = res_out.last;

endmodule

@@ tb/string_literal_escape_decoder_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for string_literal_escape_decoder: directed and random string
// bodies are driven through the byte handshake, and every result is checked against a
// local decoder model. Depends on sled_pkg and the RTL of the block.
module string_literal_escape_decoder_test;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned IdlePercent = 38;
  localparam logic [7:0]  ChZero      = 8'h30;
  localparam logic [7:0]  ChSeven     = 8'h37;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [7:0]  in_byte = '0;
  logic        end_of_input = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic [15:0] str_length;
  logic        last;

  string_literal_escape_decoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .in_byte        (in_byte),
    .end_of_input   (end_of_input),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_byte       (out_byte),
    .kind           (kind),
    .error_code     (error_code),
    .str_length     (str_length),
    .last           (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sled_pkg::item_t pending_bytes[$];
  sled_pkg::res_t  expected_results[$];
  logic [7:0]      esc_letters [6] = '{sled_pkg::CH_A, sled_pkg::CH_B, sled_pkg::CH_T,
                                       sled_pkg::CH_N, sled_pkg::CH_F, sled_pkg::CH_R};

  // Decoder model state and its copy of the length limit.
  sled_pkg::mode_t dec_mode = sled_pkg::M_NORMAL;
  logic [7:0]      oct_acc = '0;
  logic [15:0]     dec_count = '0;
  logic [15:0]     max_len = sled_pkg::MaxLengthReset;

  bit          idle_on = 1'b1;
  bit          byte_taken = 1'b0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned strings_done = 0;
  int unsigned errors_raised = 0;
  int unsigned long_errors = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic bit is_octal_digit(input logic [7:0] b);
    return b >= ChZero && b <= ChSeven;
  endfunction

  task automatic push_result(input logic [7:0] b, input logic [1:0] k, input logic [1:0] e,
                             input logic [15:0] len, input logic l);
    sled_pkg::res_t r;
    r.out_byte = b;
    r.kind = k;
    r.error_code = e;
    r.str_length = len;
    r.last = l;
    expected_results.push_back(r);
    if (k == sled_pkg::K_DONE) strings_done++;
    if (k == sled_pkg::K_ERROR) errors_raised++;
    if (e == sled_pkg::E_LONG) long_errors++;
  endtask

  task automatic raise_error(input logic [1:0] e, input sled_pkg::mode_t next_mode);
    push_result(8'h00, sled_pkg::K_ERROR, e, dec_count, 1'b1);
    dec_count = '0;
    oct_acc = '0;
    dec_mode = next_mode;
  endtask

  task automatic emit_data(input logic [7:0] b);
    dec_mode = sled_pkg::M_NORMAL;
    oct_acc = '0;
    if (dec_count >= max_len) begin
      raise_error(sled_pkg::E_LONG, sled_pkg::M_DISC);
    end else begin
      dec_count = dec_count + 16'd1;
      push_result(b, sled_pkg::K_DATA, sled_pkg::E_NONE, dec_count, 1'b0);
    end
  endtask

  // The bad octal digit itself raises the error and picks the mode that follows.
  task automatic bad_digit(input logic [7:0] b);
    if (b == sled_pkg::CH_QUOTE) raise_error(sled_pkg::E_OCTAL, sled_pkg::M_NORMAL);
    else if (b == sled_pkg::CH_BSLASH) raise_error(sled_pkg::E_OCTAL, sled_pkg::M_DISC_ESC);
    else raise_error(sled_pkg::E_OCTAL, sled_pkg::M_DISC);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    if (dec_mode == sled_pkg::M_DISC || dec_mode == sled_pkg::M_DISC_ESC) begin
      if (eoi) dec_mode = sled_pkg::M_NORMAL;
      else if (dec_mode == sled_pkg::M_DISC_ESC) dec_mode = sled_pkg::M_DISC;
      else if (b == sled_pkg::CH_QUOTE) dec_mode = sled_pkg::M_NORMAL;
      else if (b == sled_pkg::CH_BSLASH) dec_mode = sled_pkg::M_DISC_ESC;
      dec_count = '0;
      oct_acc = '0;
    end else if (eoi) begin
      raise_error(sled_pkg::E_EOF, sled_pkg::M_NORMAL);
    end else begin
      case (dec_mode)
        sled_pkg::M_ESC: begin
          case (b)
            sled_pkg::CH_A: emit_data(8'd7);
            sled_pkg::CH_B: emit_data(8'd8);
            sled_pkg::CH_T: emit_data(8'd9);
            sled_pkg::CH_N: emit_data(8'd10);
            sled_pkg::CH_F: emit_data(8'd12);
            sled_pkg::CH_R: emit_data(8'd13);
            default: begin
              if (is_octal_digit(b)) begin
                oct_acc = 8'((b - ChZero) << 6);
                dec_mode = sled_pkg::M_OCT2;
              end else begin
                emit_data(b);
              end
            end
          endcase
        end
        sled_pkg::M_OCT2: begin
          if (!is_octal_digit(b)) begin
            bad_digit(b);
          end else begin
            oct_acc = 8'(oct_acc + ((b - ChZero) << 3));
            dec_mode = sled_pkg::M_OCT3;
          end
        end
        sled_pkg::M_OCT3: begin
          if (!is_octal_digit(b)) bad_digit(b);
          else emit_data(8'(oct_acc + (b - ChZero)));
        end
        default: begin
          if (b == sled_pkg::CH_QUOTE) begin
            push_result(8'h00, sled_pkg::K_DONE, sled_pkg::E_NONE, dec_count, 1'b1);
            dec_count = '0;
            oct_acc = '0;
            dec_mode = sled_pkg::M_NORMAL;
          end else if (b == sled_pkg::CH_BSLASH) begin
            dec_mode = sled_pkg::M_ESC;
          end else begin
            emit_data(b);
          end
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic add_byte(input logic [7:0] b);
    sled_pkg::item_t it;
    it.in_byte = b;
    it.end_of_input = 1'b0;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  // The byte that travels with an end of input is ignored, so it is left random.
  task automatic add_eoi();
    sled_pkg::item_t it;
    it.in_byte = 8'($urandom_range(255));
    it.end_of_input = 1'b1;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == sled_pkg::CH_QUOTE || b == sled_pkg::CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] octal_digit();
    return ChZero + 8'($urandom_range(7));
  endfunction

  // Mostly well-formed bodies; a few tokens are broken escapes, stray bytes or an
  // early end of input.
  task automatic add_random_string(input int unsigned max_tokens);
    int unsigned n;
    int unsigned sel;
    logic [7:0]  b;
    n = $urandom_range(max_tokens);
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        add_byte(plain_byte());
      end else if (sel < 65) begin
        add_byte(sled_pkg::CH_BSLASH);
        add_byte(esc_letters[$urandom_range(5)]);
      end else if (sel < 80) begin
        add_byte(sled_pkg::CH_BSLASH);
        repeat (3) add_byte(octal_digit());
      end else if (sel < 88) begin
        b = 8'($urandom_range(255));
        add_byte(sled_pkg::CH_BSLASH);
        add_byte(b);
        if (is_octal_digit(b)) repeat (2) add_byte(octal_digit());
      end else if (sel < 93) begin
        add_byte(sled_pkg::CH_BSLASH);
        repeat ($urandom_range(2, 1)) add_byte(octal_digit());
        case ($urandom_range(2))
          0: b = sled_pkg::CH_QUOTE;
          1: b = sled_pkg::CH_BSLASH;
          default: do b = 8'($urandom_range(255)); while (is_octal_digit(b));
        endcase
        add_byte(b);
      end else if (sel < 96) begin
        add_eoi();
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) == 0) add_eoi();
    else add_byte(sled_pkg::CH_QUOTE);
  endtask

  task automatic add_random_phase(input int unsigned n, input int unsigned max_tokens);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < n) add_random_string(max_tokens);
  endtask

  // Holds until every queued byte is taken and every result is in, then lets bytes
  // that give no result clear the pipeline.
  task automatic wait_for_drain();
    while (bytes_accepted != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    max_len = value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Byte driver: a new transaction is presented only once the previous one is taken.
  always @(negedge clk) begin
    sled_pkg::item_t next_item;
    if (!rst && (!item_valid || byte_taken)) begin
      byte_taken = 1'b0;
      if (pending_bytes.size() != 0 && (!idle_on || $urandom_range(99) >= IdlePercent)) begin
        next_item = pending_bytes.pop_front();
        item_valid <= 1'b1;
        in_byte <= next_item.in_byte;
        end_of_input <= next_item.end_of_input;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_ready <= !idle_on || ($urandom_range(99) >= IdlePercent);
  end

  // Monitor: predicts on every accepted byte and checks every accepted result.
  always @(posedge clk) begin
    sled_pkg::res_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        byte_taken = 1'b1;
        bytes_accepted++;
        decode_byte(in_byte, end_of_input);
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, kind", kind, 0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_byte !== want.out_byte) report_mismatch("out_byte", out_byte, want.out_byte);
          if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
          if (error_code !== want.error_code)
            report_mismatch("error_code", error_code, want.error_code);
          if (str_length !== want.str_length)
            report_mismatch("str_length", str_length, want.str_length);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Every named escape, an octal escape that wraps, and the closing quote.
    for (int i = 0; i < 6; i++) begin
      add_byte(sled_pkg::CH_BSLASH);
      add_byte(esc_letters[i]);
    end
    add_byte(sled_pkg::CH_BSLASH);
    repeat (3) add_byte("7");
    add_byte(sled_pkg::CH_QUOTE);
    // A quote as the bad second digit ends the string straight away.
    add_byte(sled_pkg::CH_BSLASH);
    add_byte("1");
    add_byte(sled_pkg::CH_QUOTE);
    // A backslash as the bad third digit makes the discard skip the escaped quote.
    add_byte(sled_pkg::CH_BSLASH);
    add_byte("1");
    add_byte("2");
    add_byte(sled_pkg::CH_BSLASH);
    add_byte(sled_pkg::CH_QUOTE);
    add_byte(sled_pkg::CH_QUOTE);
    // End of input inside a string, then while discarding.
    add_byte(8'h00);
    add_byte(8'hFF);
    add_eoi();
    add_byte(sled_pkg::CH_BSLASH);
    add_byte("3");
    add_byte("z");
    add_eoi();
    wait_for_drain();

    idle_on = 1'b0;
    add_random_phase(90, 12);
    wait_for_drain();
    idle_on = 1'b1;

    // Limit of one: the second data byte is too long, and an empty string follows.
    write_max_length(16'd1);
    add_byte("x");
    add_byte(sled_pkg::CH_BSLASH);
    add_byte(sled_pkg::CH_N);
    add_byte(sled_pkg::CH_BSLASH);
    add_byte(sled_pkg::CH_QUOTE);
    add_byte(sled_pkg::CH_QUOTE);
    add_byte(sled_pkg::CH_QUOTE);
    add_random_phase(80, 6);
    wait_for_drain();

    write_max_length(16'hFFFF);
    add_random_phase(100, 16);
    wait_for_drain();

    write_max_length(16'd3);
    add_random_phase(90, 8);
    wait_for_drain();

    write_max_length(16'($urandom_range(12, 2)));
    add_random_phase(90, 14);
    wait_for_drain();

    $display("Sent %0d bytes over five length limits; checked %0d results.",
             bytes_accepted, results_checked);
    $display("Strings completed: %0d, errors raised: %0d (%0d over the length limit).",
             strings_done, errors_raised, long_errors);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
